/* rtl/core/llqm_pkg.sv */
`timescale 1ns / 1ps

package llqm_pkg;

   // pool size and derived widths
   localparam int NODES  = 16;
   localparam int IDX_W  = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int FLD_W  = 4;
   localparam int MODE_W = 3;

   // request modes
   localparam logic [MODE_W-1:0] MODE_ALLOC      = 3'd0;
   localparam logic [MODE_W-1:0] MODE_FREE       = 3'd1;
   localparam logic [MODE_W-1:0] MODE_INS_AFTER  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_INS_BEFORE = 3'd3;
   localparam logic [MODE_W-1:0] MODE_REMOVE     = 3'd4;

   typedef struct packed {
      logic             v;
      logic [IDX_W-1:0] i;
   } link_type;

   localparam link_type LINK_NULL = '{v: 1'b0, i: '0};

   typedef enum logic [2:0] {
      KIND_NOP,
      KIND_ALLOC,
      KIND_FREE,
      KIND_INSERT,
      KIND_REMOVE
   } kind_type;

   typedef enum logic [2:0] {
      STEP_NONE,
      STEP_EXEC,
      STEP_READ,
      STEP_LINK1,
      STEP_LINK2,
      STEP_LOOK,
      STEP_OUT
   } step_type;

   typedef struct packed {
      logic     load;
      step_type step;
   } dp_cmd_type;

   typedef struct packed {
      kind_type req_kind;
      logic     out_free;
   } dp_stat_type;

endpackage

/* rtl/core/llqm_ctrl.sv */
`timescale 1ns / 1ps

module llqm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  llqm_pkg::dp_stat_type stat,
   output llqm_pkg::dp_cmd_type  cmd
);
   import llqm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_LINK1,
      ST_LINK2,
      ST_LOOK,
      ST_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.load = 1'b0;
      cmd.step = STEP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               unique case (stat.req_kind) inside
                  KIND_ALLOC, KIND_FREE:    state_in = ST_EXEC;
                  KIND_INSERT, KIND_REMOVE: state_in = ST_READ;
                  default:                  state_in = ST_LOOK;
               endcase
            end
         end
         ST_EXEC: begin
            cmd.step = STEP_EXEC;
            state_in = ST_LOOK;
         end
         ST_READ: begin
            cmd.step = STEP_READ;
            state_in = ST_LINK1;
         end
         ST_LINK1: begin
            cmd.step = STEP_LINK1;
            state_in = ST_LINK2;
         end
         ST_LINK2: begin
            cmd.step = STEP_LINK2;
            state_in = ST_LOOK;
         end
         ST_LOOK: begin
            cmd.step = STEP_LOOK;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            cmd.step = STEP_OUT;
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

/* rtl/core/llqm_dp.sv */
`timescale 1ns / 1ps

module llqm_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  llqm_pkg::dp_cmd_type               cmd,
   output llqm_pkg::dp_stat_type              stat,
   input  logic [llqm_pkg::MODE_W-1:0]        req_mode,
   input  logic                               req_node_present,
   input  logic [llqm_pkg::FLD_W-1:0]         req_node_index,
   input  logic                               req_other_present,
   input  logic [llqm_pkg::FLD_W-1:0]         req_other_index,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_status,
   output logic [llqm_pkg::FLD_W-1:0]         rsp_alloc_index,
   output logic                               rsp_head_present,
   output logic [llqm_pkg::FLD_W-1:0]         rsp_head_index,
   output logic                               rsp_tail_present,
   output logic [llqm_pkg::FLD_W-1:0]         rsp_tail_index,
   output logic                               rsp_next_present,
   output logic [llqm_pkg::FLD_W-1:0]         rsp_next_index,
   output logic                               rsp_prev_present,
   output logic [llqm_pkg::FLD_W-1:0]         rsp_prev_index
);
   import llqm_pkg::*;

   // request decode
   logic     node_ok, other_ok, ins_ok, sel_ok;
   kind_type kind;

   // latched request
   logic [MODE_W-1:0] mode_ff;
   logic              op_ff;
   logic [IDX_W-1:0]  ni_ff, oi_ff;
   kind_type          kind_ff;

   // result bookkeeping
   logic [IDX_W-1:0] sel_ff, sel_in;
   logic             has_sel_ff, has_sel_in;
   logic             status_ff, status_in;
   logic [IDX_W-1:0] alloc_ff, alloc_in;

   // list state
   logic [NODES-1:0] free_ff, free_in;
   logic [NODES-1:0] nxt_v_ff, prv_v_ff;
   logic [IDX_W-1:0] nxt_mem [NODES];
   logic [IDX_W-1:0] prv_mem [NODES];
   link_type         head_ff, head_in, tail_ff, tail_in;
   logic [IDX_W-1:0] start_ff, start_in;

   // link read registers
   link_type         nrd_ff, prd_ff;
   logic             rd_en;
   logic [IDX_W-1:0] nr_addr, pr_addr;

   // write ports
   logic             nw_en, pw_en;
   logic [IDX_W-1:0] nw_addr, pw_addr;
   link_type         nw_data, pw_data;

   // free slot search
   logic [NODES-1:0] hi_mask, masked, pick_src, pick_oh;
   logic [IDX_W-1:0] grant;
   logic             found;

   link_type t_link, u_link, mk_ni, mk_oi;

   // output register
   logic             rsp_valid_ff, out_load;
   logic             rsp_status_ff;
   logic [FLD_W-1:0] rsp_alloc_ff;
   link_type         rsp_head_ff, rsp_tail_ff, rsp_next_ff, rsp_prev_ff;
   link_type         look_next, look_prev;

   assign node_ok  = req_node_present && (int'(req_node_index) < NODES);
   assign other_ok = req_other_present && (int'(req_other_index) < NODES) &&
                     (req_other_index != req_node_index);
   assign ins_ok   = node_ok && (!req_other_present || other_ok);
   assign sel_ok   = node_ok && ((req_mode == MODE_FREE) || (req_mode == MODE_INS_AFTER) ||
                                 (req_mode == MODE_INS_BEFORE) || (req_mode == MODE_REMOVE));

   always_comb begin
      unique case (req_mode)
         MODE_ALLOC:      kind = KIND_ALLOC;
         MODE_FREE:       kind = node_ok ? KIND_FREE : KIND_NOP;
         MODE_INS_AFTER:  kind = ins_ok ? KIND_INSERT : KIND_NOP;
         MODE_INS_BEFORE: kind = ins_ok ? KIND_INSERT : KIND_NOP;
         MODE_REMOVE:     kind = node_ok ? KIND_REMOVE : KIND_NOP;
         default:         kind = KIND_NOP;
      endcase
   end

   assign out_load      = (cmd.step == STEP_OUT) && (!rsp_valid_ff || !rsp_stall);
   assign stat.req_kind = kind;
   assign stat.out_free = !rsp_valid_ff || !rsp_stall;

   // round-robin search: first free slot at or above start, else first free overall
   always_comb begin
      for (int k = 0; k < NODES; k++) hi_mask[k] = (k >= int'(start_ff));
      masked   = free_ff & hi_mask;
      pick_src = (|masked) ? masked : free_ff;
      pick_oh  = pick_src & (~pick_src + NODES'(1));
      found    = |free_ff;
      grant    = '0;
      for (int k = 0; k < NODES; k++) begin
         if (pick_oh[k]) grant = grant | IDX_W'(k);
      end
   end

   assign mk_ni  = '{v: 1'b1, i: ni_ff};
   assign mk_oi  = '{v: 1'b1, i: oi_ff};
   assign u_link = prd_ff;

   always_comb begin
      unique case (mode_ff)
         MODE_INS_AFTER:  t_link = op_ff ? nrd_ff : head_ff;
         MODE_INS_BEFORE: t_link = op_ff ? prd_ff : tail_ff;
         default:         t_link = nrd_ff;
      endcase
   end

   // read addressing
   always_comb begin
      rd_en   = 1'b0;
      nr_addr = sel_ff;
      pr_addr = sel_ff;
      if (cmd.step == STEP_READ) begin
         rd_en   = 1'b1;
         nr_addr = (mode_ff == MODE_REMOVE) ? ni_ff : oi_ff;
         pr_addr = (mode_ff == MODE_REMOVE) ? ni_ff : oi_ff;
      end else if (cmd.step == STEP_LOOK) begin
         rd_en = 1'b1;
      end
   end

   // per-step update of links, ends, pool and bookkeeping
   always_comb begin
      nw_en      = 1'b0;
      nw_addr    = ni_ff;
      nw_data    = LINK_NULL;
      pw_en      = 1'b0;
      pw_addr    = ni_ff;
      pw_data    = LINK_NULL;
      head_in    = head_ff;
      tail_in    = tail_ff;
      free_in    = free_ff;
      start_in   = start_ff;
      sel_in     = sel_ff;
      has_sel_in = has_sel_ff;
      status_in  = status_ff;
      alloc_in   = alloc_ff;
      if (cmd.load) begin
         sel_in     = IDX_W'(req_node_index);
         has_sel_in = sel_ok;
         status_in  = 1'b0;
         alloc_in   = '0;
      end else begin
         case (cmd.step)
            STEP_EXEC: begin
               if (kind_ff == KIND_ALLOC) begin
                  if (found) begin
                     free_in[grant] = 1'b0;
                     nw_en      = 1'b1;
                     nw_addr    = grant;
                     pw_en      = 1'b1;
                     pw_addr    = grant;
                     start_in   = (grant == IDX_W'(NODES - 1)) ? '0 : grant + 1'b1;
                     sel_in     = grant;
                     has_sel_in = 1'b1;
                     alloc_in   = grant;
                  end else begin
                     status_in  = 1'b1;
                     has_sel_in = 1'b0;
                  end
               end else begin
                  free_in[ni_ff] = 1'b1;
                  nw_en = 1'b1;
                  pw_en = 1'b1;
               end
            end
            STEP_LINK1: begin
               unique case (mode_ff)
                  MODE_INS_AFTER: begin
                     if (t_link.v) begin
                        pw_en   = 1'b1;
                        pw_addr = t_link.i;
                        pw_data = mk_ni;
                     end else if (op_ff) begin
                        tail_in = mk_ni;
                     end
                     nw_en   = 1'b1;
                     nw_data = t_link;
                  end
                  MODE_INS_BEFORE: begin
                     if (t_link.v) begin
                        nw_en   = 1'b1;
                        nw_addr = t_link.i;
                        nw_data = mk_ni;
                     end else if (op_ff) begin
                        head_in = mk_ni;
                     end
                     pw_en   = 1'b1;
                     pw_data = t_link;
                  end
                  default: begin
                     if (head_ff.v && (head_ff.i == ni_ff)) head_in = t_link;
                     if (tail_ff.v && (tail_ff.i == ni_ff)) tail_in = u_link;
                     if (t_link.v) begin
                        pw_en   = 1'b1;
                        pw_addr = t_link.i;
                        pw_data = u_link;
                     end
                     if (u_link.v) begin
                        nw_en   = 1'b1;
                        nw_addr = u_link.i;
                        nw_data = t_link;
                     end
                  end
               endcase
            end
            STEP_LINK2: begin
               unique case (mode_ff)
                  MODE_INS_AFTER: begin
                     pw_en   = 1'b1;
                     pw_data = op_ff ? mk_oi : LINK_NULL;
                     if (op_ff) begin
                        nw_en   = 1'b1;
                        nw_addr = oi_ff;
                        nw_data = mk_ni;
                     end else begin
                        head_in = mk_ni;
                        if (!tail_ff.v) tail_in = mk_ni;
                     end
                  end
                  MODE_INS_BEFORE: begin
                     nw_en   = 1'b1;
                     nw_data = op_ff ? mk_oi : LINK_NULL;
                     if (op_ff) begin
                        pw_en   = 1'b1;
                        pw_addr = oi_ff;
                        pw_data = mk_ni;
                     end else begin
                        tail_in = mk_ni;
                        if (!head_ff.v) head_in = mk_ni;
                     end
                  end
                  default: begin
                     nw_en = 1'b1;
                     pw_en = 1'b1;
                  end
               endcase
            end
            default: ;
         endcase
      end
   end

   assign look_next = (has_sel_ff && nrd_ff.v) ? nrd_ff : LINK_NULL;
   assign look_prev = (has_sel_ff && prd_ff.v) ? prd_ff : LINK_NULL;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff      <= '1;
         nxt_v_ff     <= '0;
         prv_v_ff     <= '0;
         head_ff      <= LINK_NULL;
         tail_ff      <= LINK_NULL;
         start_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         free_ff  <= free_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         start_ff <= start_in;
         if (nw_en) nxt_v_ff[nw_addr] <= nw_data.v;
         if (pw_en) prv_v_ff[pw_addr] <= pw_data.v;
         if (out_load)        rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // link index memories
   always_ff @(posedge clock) begin
      if (nw_en) nxt_mem[nw_addr] <= nw_data.i;
      if (pw_en) prv_mem[pw_addr] <= pw_data.i;
      if (rd_en) begin
         nrd_ff <= '{v: nxt_v_ff[nr_addr], i: nxt_mem[nr_addr]};
         prd_ff <= '{v: prv_v_ff[pr_addr], i: prv_mem[pr_addr]};
      end
   end

   // request and result payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         op_ff   <= req_other_present;
         ni_ff   <= IDX_W'(req_node_index);
         oi_ff   <= IDX_W'(req_other_index);
         kind_ff <= kind;
      end
      sel_ff     <= sel_in;
      has_sel_ff <= has_sel_in;
      status_ff  <= status_in;
      alloc_ff   <= alloc_in;
      if (out_load) begin
         rsp_status_ff <= status_ff;
         rsp_alloc_ff  <= FLD_W'(alloc_ff);
         rsp_head_ff   <= head_ff;
         rsp_tail_ff   <= tail_ff;
         rsp_next_ff   <= look_next;
         rsp_prev_ff   <= look_prev;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_alloc_index  = rsp_alloc_ff;
   assign rsp_head_present = rsp_head_ff.v;
   assign rsp_head_index   = rsp_head_ff.v ? FLD_W'(rsp_head_ff.i) : '0;
   assign rsp_tail_present = rsp_tail_ff.v;
   assign rsp_tail_index   = rsp_tail_ff.v ? FLD_W'(rsp_tail_ff.i) : '0;
   assign rsp_next_present = rsp_next_ff.v;
   assign rsp_next_index   = rsp_next_ff.v ? FLD_W'(rsp_next_ff.i) : '0;
   assign rsp_prev_present = rsp_prev_ff.v;
   assign rsp_prev_index   = rsp_prev_ff.v ? FLD_W'(rsp_prev_ff.i) : '0;

endmodule

/* rtl/core/linked_list_queue_manager.sv */
`timescale 1ns / 1ps
// Linked list queue manager: a pool of NODES slots, allocated ones linked
// into one doubly linked list (allocate, free, insert after/before, remove).
// Request channel req_*: mode, node and reference slot, taken on an edge
// with req_valid high and req_stall low. Response channel rsp_*: status,
// granted slot, list head/tail and the links of the node operated on, taken
// with rsp_valid high and rsp_stall low. Exactly one response per request.
// One request is in work at a time; the next is taken only once the
// sequencer is back in its idle state. Allocate and free pass through an
// EXEC step; insert and remove need a link read step (READ) and then the
// link write steps LINK1 and LINK2, as each link memory has a single write
// port. Every request ends with a read of the node's links (LOOK) and the
// hand-off to the output register (DONE).
// The free-slot search is a combinational rotating priority pick.
// A response waits in the output register while the receiver stalls; the
// next request is still taken and worked on, and only its final hand-off
// to the output register waits.
// Reset (synchronous, active high) frees every slot, clears every link and
// the head and tail, and sets the allocate search start to slot 0.

module linked_list_queue_manager (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [llqm_pkg::MODE_W-1:0] req_mode,
   input  logic                        req_node_present,
   input  logic [llqm_pkg::FLD_W-1:0]  req_node_index,
   input  logic                        req_other_present,
   input  logic [llqm_pkg::FLD_W-1:0]  req_other_index,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_status,
   output logic [llqm_pkg::FLD_W-1:0]  rsp_alloc_index,
   output logic                        rsp_head_present,
   output logic [llqm_pkg::FLD_W-1:0]  rsp_head_index,
   output logic                        rsp_tail_present,
   output logic [llqm_pkg::FLD_W-1:0]  rsp_tail_index,
   output logic                        rsp_next_present,
   output logic [llqm_pkg::FLD_W-1:0]  rsp_next_index,
   output logic                        rsp_prev_present,
   output logic [llqm_pkg::FLD_W-1:0]  rsp_prev_index
);
   import llqm_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // sequencer: walks each request through its read and write steps
   llqm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // pool, link memories, head/tail and the output register
   llqm_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_mode          (req_mode),
      .req_node_present  (req_node_present),
      .req_node_index    (req_node_index),
      .req_other_present (req_other_present),
      .req_other_index   (req_other_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_alloc_index   (rsp_alloc_index),
      .rsp_head_present  (rsp_head_present),
      .rsp_head_index    (rsp_head_index),
      .rsp_tail_present  (rsp_tail_present),
      .rsp_tail_index    (rsp_tail_index),
      .rsp_next_present  (rsp_next_present),
      .rsp_next_index    (rsp_next_index),
      .rsp_prev_present  (rsp_prev_present),
      .rsp_prev_index    (rsp_prev_index)
   );

   // a taken request leaves the sequencer busy in the following cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted but sequencer not busy");

   // a fresh response only comes out of a request in work
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response without a request in work");

   // an empty pool grants nothing and reports no node links
   a_none_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |->
         (rsp_alloc_index == '0) && !rsp_next_present && !rsp_prev_present)
      else $error("failed allocate reports a slot");

endmodule
